@@ rtl/rme_pkg.sv @@
// ----------------------------------------------------------------------------
// rme_pkg
// Types, constants and the arctangent table shared by the rotation matrix to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package rme_pkg;

	localparam int SQRT_STEPS = 16;
	localparam int TOL_W      = 11;
	localparam int XY_W       = 34;
	localparam int Z_W        = 35;

	localparam logic signed [16:0] ONE_Q14     = 17'sd16384;
	localparam logic signed [15:0] PI_Q13      = 16'sd25736;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
	localparam logic signed [Z_W-1:0] PI_Q30   = 35'sd3373259426;

	localparam logic [1:0] CASE_LOCK_NEG = 2'd0;
	localparam logic [1:0] CASE_LOCK_POS = 2'd1;
	localparam logic [1:0] CASE_GENERAL  = 2'd2;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m22;
	} in_t;

	typedef struct packed {
		logic signed [16:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic [1:0]         solution_case;
	} out_t;

	// Operands for the four lanes that do not depend on the square root.
	typedef struct packed {
		logic signed [16:0] y1;
		logic signed [16:0] x1;
		logic signed [16:0] y2;
		logic signed [16:0] x2;
		logic signed [16:0] y3;
		logic signed [16:0] x3;
		logic signed [16:0] y4;
		logic signed [16:0] x4;
		logic signed [16:0] s;
		logic [1:0]         sol_case;
	} mid_t;

	typedef struct packed {
		logic [31:0] v;
		logic [31:0] r;
	} sq_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
		logic                   neg;
	} cordic_t;

	function automatic logic [30:0] atan_tab(input int idx);
		logic [30:0] t;
		case (idx)
			0: t = 31'd843314856;
			1: t = 31'd497837829;
			2: t = 31'd263043836;
			3: t = 31'd133525158;
			4: t = 31'd67021686;
			5: t = 31'd33543515;
			6: t = 31'd16775850;
			7: t = 31'd8388437;
			8: t = 31'd4194282;
			9: t = 31'd2097149;
			10: t = 31'd1048575;
			11: t = 31'd524287;
			12: t = 31'd262143;
			13: t = 31'd131071;
			14: t = 31'd65535;
			15: t = 31'd32767;
			16: t = 31'd16383;
			17: t = 31'd8191;
			18: t = 31'd4095;
			19: t = 31'd2047;
			20: t = 31'd1023;
			21: t = 31'd511;
			22: t = 31'd255;
			23: t = 31'd127;
			default: t = 31'd0;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/rotation_matrix_to_euler_core.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_core
// Rotation matrix to Euler angles through square root and CORDIC cell chains.
// ----------------------------------------------------------------------------
// One item is accepted per cycle, except while the pipeline holds; an item passes
// through one input stage, a 16-cell square root chain, five parallel
// atan2 lanes of CORDIC_STAGES cells plus fold and rounding stages, and the
// output register. The whole pipeline holds while a result waits to be taken.
module rotation_matrix_to_euler_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rme_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rme_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [10:0]   cfg_data
);
	localparam int SQ  = rme_pkg::SQRT_STEPS;
	localparam int LD  = CORDIC_STAGES + 2;
	localparam int LAT = 1 + SQ + LD + 1;

	logic [10:0]    tol_q;
	logic [LAT-1:0] vld_q;
	logic           en;

	logic signed [16:0] m02e, dneg, dpos, s_sat;
	logic               lock_neg, lock_pos;
	logic signed [33:0] s_sq;
	rme_pkg::mid_t      mid_in;
	rme_pkg::mid_t      mid_d [SQ+1];
	rme_pkg::sq_t       sq [SQ+1];
	logic [1:0]         case_d [LD+1];

	logic signed [15:0] a0, a1, a2, a3, a4;
	logic signed [16:0] x1, x2;
	logic [18:0]        sum1, sum2;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
			vld_q <= '0;
		end else begin
			if (cfg_valid)
				tol_q <= cfg_data;
			if (en)
				vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Lock test on the raw m02, then operand choice for the lanes.
	always_comb begin
		m02e     = 17'(in_data.m02);
		dneg     = m02e + rme_pkg::ONE_Q14;
		dpos     = m02e - rme_pkg::ONE_Q14;
		if (dneg[16]) dneg = -dneg;
		if (dpos[16]) dpos = -dpos;
		lock_neg = (dneg <= $signed({6'd0, tol_q}));
		lock_pos = (dpos <= $signed({6'd0, tol_q}));
		if (m02e > rme_pkg::ONE_Q14)
			s_sat = rme_pkg::ONE_Q14;
		else if (m02e < -rme_pkg::ONE_Q14)
			s_sat = -rme_pkg::ONE_Q14;
		else
			s_sat = m02e;
		s_sq = s_sat * s_sat;

		mid_in.s  = s_sat;
		mid_in.y1 = 17'(in_data.m12);
		mid_in.x1 = 17'(in_data.m22);
		mid_in.y2 = -17'(in_data.m12);
		mid_in.x2 = -17'(in_data.m22);
		mid_in.y4 = -17'(in_data.m01);
		mid_in.x4 = -17'(in_data.m00);
		if (lock_neg) begin
			mid_in.sol_case = rme_pkg::CASE_LOCK_NEG;
			mid_in.y3 = 17'(in_data.m10);
			mid_in.x3 = 17'(in_data.m20);
		end else if (lock_pos) begin
			mid_in.sol_case = rme_pkg::CASE_LOCK_POS;
			mid_in.y3 = -17'(in_data.m10);
			mid_in.x3 = -17'(in_data.m20);
		end else begin
			mid_in.sol_case = rme_pkg::CASE_GENERAL;
			mid_in.y3 = 17'(in_data.m01);
			mid_in.x3 = 17'(in_data.m00);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_d[0] <= mid_in;
			sq[0].v  <= 32'd268435456 - 32'(s_sq);
			sq[0].r  <= '0;
		end
	end

	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		rme_sqrt_cell #(.IDX(i)) u_sqrt (
			.clk (clk),
			.en  (en),
			.d   (sq[i]),
			.q   (sq[i+1])
		);
		always_ff @(posedge clk) begin
			if (en)
				mid_d[i+1] <= mid_d[i];
		end
	end

	rme_atan2 #(.STAGES(CORDIC_STAGES)) u_lane0 (
		.clk(clk), .en(en), .y(mid_d[SQ].s), .x(sq[SQ].r[16:0]), .angle(a0));
	rme_atan2 #(.STAGES(CORDIC_STAGES)) u_lane1 (
		.clk(clk), .en(en), .y(mid_d[SQ].y1), .x(mid_d[SQ].x1), .angle(a1));
	rme_atan2 #(.STAGES(CORDIC_STAGES)) u_lane2 (
		.clk(clk), .en(en), .y(mid_d[SQ].y2), .x(mid_d[SQ].x2), .angle(a2));
	rme_atan2 #(.STAGES(CORDIC_STAGES)) u_lane3 (
		.clk(clk), .en(en), .y(mid_d[SQ].y3), .x(mid_d[SQ].x3), .angle(a3));
	rme_atan2 #(.STAGES(CORDIC_STAGES)) u_lane4 (
		.clk(clk), .en(en), .y(mid_d[SQ].y4), .x(mid_d[SQ].x4), .angle(a4));

	assign case_d[0] = mid_d[SQ].sol_case;
	for (genvar i = 0; i < LD; i++) begin : g_case
		always_ff @(posedge clk) begin
			if (en)
				case_d[i+1] <= case_d[i];
		end
	end

	// Pick the solution with the smaller sum of absolute angles.
	always_comb begin
		x1   = -17'(a0);
		x2   = 17'(rme_pkg::PI_Q13) - x1;
		sum1 = 19'(x1[16] ? -x1 : x1) + 19'(a1[15] ? -a1 : a1) + 19'(a3[15] ? -a3 : a3);
		sum2 = 19'(x2[16] ? -x2 : x2) + 19'(a2[15] ? -a2 : a2) + 19'(a4[15] ? -a4 : a4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.solution_case <= case_d[LD];
			case (case_d[LD])
				rme_pkg::CASE_LOCK_NEG: begin
					out_data.angle_x <= '0;
					out_data.angle_y <= rme_pkg::HALF_PI_Q13;
					out_data.angle_z <= a3;
				end
				rme_pkg::CASE_LOCK_POS: begin
					out_data.angle_x <= '0;
					out_data.angle_y <= -rme_pkg::HALF_PI_Q13;
					out_data.angle_z <= a3;
				end
				default: begin
					if (sum1 <= sum2) begin
						out_data.angle_x <= x1;
						out_data.angle_y <= a1;
						out_data.angle_z <= a3;
					end else begin
						out_data.angle_x <= x2;
						out_data.angle_y <= a2;
						out_data.angle_z <= a4;
					end
				end
			endcase
		end
	end

	a_lock_x_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.solution_case != rme_pkg::CASE_GENERAL |-> out_data.angle_x == '0)
		else $error("lock result with nonzero angle_x");
	a_case_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.solution_case == rme_pkg::CASE_LOCK_NEG ||
			out_data.solution_case == rme_pkg::CASE_LOCK_POS ||
			out_data.solution_case == rme_pkg::CASE_GENERAL))
		else $error("illegal solution case");
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");
	a_hold_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("waiting result lost");
endmodule

@@ rtl/rme_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// rme_sqrt_cell
// One restoring step of the integer square root; the cells form a chain.
// ----------------------------------------------------------------------------
module rme_sqrt_cell #(
	parameter int IDX = 0
) (
	input  logic         clk,
	input  logic         en,
	input  rme_pkg::sq_t d,
	output rme_pkg::sq_t q
);
	localparam logic [31:0] BIT = 32'd1 << (30 - 2 * IDX);

	logic [31:0] trial;

	assign trial = d.r + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (d.v >= trial) begin
				q.v <= d.v - trial;
				q.r <= (d.r >> 1) + BIT;
			end else begin
				q.v <= d.v;
				q.r <= d.r >> 1;
			end
		end
	end
endmodule

@@ rtl/rme_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// rme_cordic_cell
// One vectoring CORDIC micro-rotation with its own arctangent constant.
// ----------------------------------------------------------------------------
module rme_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             en,
	input  rme_pkg::cordic_t d,
	output rme_pkg::cordic_t q
);
	localparam logic signed [rme_pkg::Z_W-1:0] ANG =
		rme_pkg::Z_W'(rme_pkg::atan_tab(IDX));

	logic signed [rme_pkg::XY_W-1:0] dx, dy;

	assign dx = d.y >>> IDX;
	assign dy = d.x >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			q.zero <= d.zero;
			q.neg  <= d.neg;
			if (!d.y[rme_pkg::XY_W-1]) begin
				q.x <= d.x + dx;
				q.y <= d.y - dy;
				q.z <= d.z + ANG;
			end else begin
				q.x <= d.x - dx;
				q.y <= d.y + dy;
				q.z <= d.z - ANG;
			end
		end
	end
endmodule

@@ rtl/rme_atan2.sv @@
// ----------------------------------------------------------------------------
// rme_atan2
// atan2 lane: quadrant fold, a chain of CORDIC cells, rounding to Q3.13.
// ----------------------------------------------------------------------------
module rme_atan2 #(
	parameter int STAGES = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [16:0] y,
	input  logic signed [16:0] x,
	output logic signed [15:0] angle
);
	localparam int XW = rme_pkg::XY_W;
	localparam int ZW = rme_pkg::Z_W;

	rme_pkg::cordic_t chain [STAGES+1];
	logic signed [16:0] yf, xf;
	logic signed [ZW-1:0] zr;
	logic signed [ZW-1:0] zsh;

	// Fold the left half plane onto the right half before rotating.
	assign yf = x[16] ? -y : y;
	assign xf = x[16] ? -x : x;

	always_ff @(posedge clk) begin
		if (en) begin
			chain[0].x    <= XW'(xf) <<< 14;
			chain[0].y    <= XW'(yf) <<< 14;
			chain[0].zero <= (y == 17'sd0);
			chain[0].neg  <= x[16];
			if (!x[16])
				chain[0].z <= '0;
			else if (!y[16])
				chain[0].z <= rme_pkg::PI_Q30;
			else
				chain[0].z <= -rme_pkg::PI_Q30;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		rme_cordic_cell #(.IDX(i)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (chain[i]),
			.q   (chain[i+1])
		);
	end

	assign zr  = chain[STAGES].z + ZW'(65536);
	assign zsh = zr >>> 17;

	always_ff @(posedge clk) begin
		if (en) begin
			if (chain[STAGES].zero)
				angle <= chain[STAGES].neg ? rme_pkg::PI_Q13 : 16'sd0;
			else if (zsh > ZW'(rme_pkg::PI_Q13))
				angle <= rme_pkg::PI_Q13;
			else if (zsh < -ZW'(rme_pkg::PI_Q13))
				angle <= -rme_pkg::PI_Q13;
			else
				angle <= zsh[15:0];
		end
	end
endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the rotation matrix to Euler angle core. Directed matrices and random
// ones go in through a stalling sender, results are taken by a stalling receiver,
// and each is compared with a local bit-exact predictor or with typed values.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int STAGES    = 16;
	localparam int LATENCY   = STAGES + 20;
	localparam int WD_LIMIT  = 20000;
	localparam int N_RANDOM  = 450;
	localparam int N_DIRECT  = 18;
	localparam logic [63:0] PI_FULL = 64'd3373259426;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rme_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rme_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [10:0] cfg_data = '0;

	logic [10:0] tol_shadow;
	rme_pkg::out_t angles_pending[$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;

	rotation_matrix_to_euler_core #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic int atan2_q13(longint y, longint x);
		longint z, dx, dy, r;
		int i;
		z = 0;
		if (y == 0)
			return (x < 0) ? int'(rme_pkg::PI_Q13) : 0;
		if (x < 0) begin
			z = (y >= 0) ? longint'(PI_FULL) : -longint'(PI_FULL);
			x = -x;
			y = -y;
		end
		x = x * 16384;
		y = y * 16384;
		for (i = 0; i < STAGES; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(rme_pkg::atan_tab(i));
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(rme_pkg::atan_tab(i));
			end
		end
		r = shr_floor(z + 65536, 17);
		if (r > 25736) r = 25736;
		if (r < -25736) r = -25736;
		return int'(r);
	endfunction

	function automatic longint floor_sqrt(longint v);
		longint r;
		r = longint'($sqrt(real'(v)));
		while (r * r > v) r--;
		while ((r + 1) * (r + 1) <= v) r++;
		return r;
	endfunction

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic rme_pkg::out_t predict_angles(rme_pkg::in_t m, logic [10:0] tol);
		rme_pkg::out_t o;
		longint s, c, dneg, dpos;
		int x1, x2, y1, y2, z1, z2;
		s = m.m02;
		dneg = s + 16384;
		dpos = s - 16384;
		if (dneg < 0) dneg = -dneg;
		if (dpos < 0) dpos = -dpos;
		if (dneg <= tol) begin
			o.angle_x = '0;
			o.angle_y = rme_pkg::HALF_PI_Q13;
			o.angle_z = 16'(atan2_q13(m.m10, m.m20));
			o.solution_case = rme_pkg::CASE_LOCK_NEG;
		end else if (dpos <= tol) begin
			o.angle_x = '0;
			o.angle_y = -rme_pkg::HALF_PI_Q13;
			o.angle_z = 16'(atan2_q13(-longint'(m.m10), -longint'(m.m20)));
			o.solution_case = rme_pkg::CASE_LOCK_POS;
		end else begin
			if (s > 16384) s = 16384;
			if (s < -16384) s = -16384;
			c = floor_sqrt(16384 * 16384 - s * s);
			x1 = -atan2_q13(s, c);
			x2 = 25736 - x1;
			y1 = atan2_q13(m.m12, m.m22);
			y2 = atan2_q13(-longint'(m.m12), -longint'(m.m22));
			z1 = atan2_q13(m.m01, m.m00);
			z2 = atan2_q13(-longint'(m.m01), -longint'(m.m00));
			if (mag(x1) + mag(y1) + mag(z1) <= mag(x2) + mag(y2) + mag(z2)) begin
				o.angle_x = 17'(x1);
				o.angle_y = 16'(y1);
				o.angle_z = 16'(z1);
			end else begin
				o.angle_x = 17'(x2);
				o.angle_y = 16'(y2);
				o.angle_z = 16'(z2);
			end
			o.solution_case = rme_pkg::CASE_GENERAL;
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic logic signed [15:0] rand_entry();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic rme_pkg::in_t rand_matrix(logic [10:0] tol);
		rme_pkg::in_t m;
		m.m00 = rand_entry();
		m.m01 = rand_entry();
		m.m10 = rand_entry();
		m.m12 = rand_entry();
		m.m20 = rand_entry();
		m.m22 = rand_entry();
		case ($urandom_range(0, 5))
			// Near the lock points, just inside or just outside the tolerance.
			0: m.m02 = 16'(-16384 + int'($urandom_range(0, tol + 2)) - 1);
			1: m.m02 = 16'(16384 - int'($urandom_range(0, tol + 2)) + 1);
			2: m.m02 = 16'($urandom);
			default: m.m02 = rand_entry();
		endcase
		return m;
	endfunction

	// Valid stays high after an accepted item and, within this task, drops only when a gap is drawn.
	task automatic send_item(rme_pkg::in_t m, int max_gap);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= m;
		angles_pending.push_back(predict_angles(m, tol_shadow));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [10:0] v);
		in_valid <= 1'b0;
		while (angles_pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tol_shadow = v;
	endtask

	// Receiver: random stalls, with one long hold-off to back up the pipeline.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (angles_pending.size() == 0) begin
					$display("unexpected result at %0t", $time);
					errors++;
				end else begin
					rme_pkg::out_t want;
					want = angles_pending.pop_front();
					if (out_data.angle_x !== want.angle_x)
						report_mismatch("angle_x", out_data.angle_x, want.angle_x);
					if (out_data.angle_y !== want.angle_y)
						report_mismatch("angle_y", out_data.angle_y, want.angle_y);
					if (out_data.angle_z !== want.angle_z)
						report_mismatch("angle_z", out_data.angle_z, want.angle_z);
					if (out_data.solution_case !== want.solution_case)
						report_mismatch("solution_case", out_data.solution_case,
							want.solution_case);
				end
			end
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Watchdog on cycles with no accepted item on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	rme_pkg::in_t direct_in[N_DIRECT];
	rme_pkg::out_t direct_out[N_DIRECT];
	bit direct_known[N_DIRECT];

	initial begin
		logic [10:0] tols[5];
		int phase, k;
		tol_shadow = '0;
		tols = '{11'd0, 11'd1, 11'd1024, 11'd37, 11'd2047};
		for (k = 0; k < N_DIRECT; k++) begin
			direct_in[k] = '0;
			direct_known[k] = 1'b0;
		end
		// Exact locks: angle_x 0, angle_y +-pi/2, angle_z 0 when m10 is zero.
		direct_in[0] = '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0};
		direct_out[0] = '{17'sd0, rme_pkg::HALF_PI_Q13, 16'sd0, rme_pkg::CASE_LOCK_NEG};
		direct_known[0] = 1'b1;
		direct_in[1] = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'sd0};
		direct_out[1] = '{17'sd0, -rme_pkg::HALF_PI_Q13, 16'sd0, rme_pkg::CASE_LOCK_POS};
		direct_known[1] = 1'b1;
		// Identity matrix gives all zero angles.
		direct_in[2] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
		direct_out[2] = '{17'sd0, 16'sd0, 16'sd0, rme_pkg::CASE_GENERAL};
		direct_known[2] = 1'b1;
		// Zero vectors and zero y with negative x.
		direct_in[3] = '0;
		direct_in[4] = '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384};
		// Out of range m02 on both sides, raw extremes, and m02 one step inside each lock point.
		direct_in[5] = '{16'sd100, -16'sd100, 16'sh7fff, 16'sd5, 16'sd7, 16'sd9, 16'sd11};
		direct_in[6] = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh8000};
		direct_in[7] = '{16'shffff, 16'sh5555, 16'sh2aaa, 16'shaaaa, 16'sh5555, 16'sh8001,
			16'sh7ffe};
		direct_in[8] = '{-16'sd16384, -16'sd16384, -16'sd16383, 16'sd16384, -16'sd16384,
			16'sd16384, 16'sd16384};
		direct_in[9] = '{16'sd0, 16'sd16384, 16'sd16383, -16'sd16384, 16'sd16384,
			-16'sd16384, -16'sd16384};
		for (k = 10; k < N_DIRECT; k++)
			direct_in[k] = rand_matrix(11'd0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIRECT; k++) begin
			if (direct_known[k] && predict_angles(direct_in[k], tol_shadow) != direct_out[k])
				$display("note: typed row %0d differs from predictor", k);
			send_item(direct_in[k], 7);
			if (direct_known[k])
				angles_pending[$] = direct_out[k];
		end

		for (phase = 0; phase < 5; phase++) begin
			write_tolerance(tols[phase]);
			if (phase == 2)
				hold_off = 1'b1;
			for (k = 0; k < N_RANDOM / 5; k++) begin
				// Back to back items while the receiver holds off.
				if (phase == 2 && k < 60)
					send_item(rand_matrix(tol_shadow), 0);
				else
					send_item(rand_matrix(tol_shadow), 7);
			end
		end
		in_valid <= 1'b0;

		while (angles_pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
